FILE: hdl/wavhdr_pkg.sv
// wavhdr_pkg: request and result types, chunk tags and codes for the wav header parser
// no dependencies; imported by wav_header_chunk_parser_unit
package wavhdr_pkg;

    // one input byte of the file
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_req_t;

    // one parse result, emitted after the last byte of a file
    typedef struct packed {
        logic [2:0]  parse_status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [12:0] bytes_per_sample;
        logic [30:0] sample_count;
        logic [31:0] data_offset;
    } result_t;

    localparam int WIDTH_W = 13;
    localparam int COUNT_W = 31;
    localparam int LEN_W   = 32;
    localparam int NCS_W   = 33;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [NCS_W-1:0] HDR_BYTES = 33'd8;
    localparam logic [NCS_W-1:0] RIFF_HDR  = 33'd12;

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_WAVE = 2'd1;
    localparam logic [1:0] PH_SUB  = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    localparam int FL_WAVE = 0;
    localparam int FL_FMT  = 1;
    localparam int FL_DATA = 2;

    localparam logic [4:0] CAP_IDLE = 5'd16;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_RIFF    = 3'd1;
    localparam logic [2:0] ST_NO_FMT     = 3'd2;
    localparam logic [2:0] ST_NOT_PCM    = 3'd3;
    localparam logic [2:0] ST_NO_DATA    = 3'd4;
    localparam logic [2:0] ST_ZERO_WIDTH = 3'd5;

    localparam logic [15:0] FMT_PCM = 16'd1;

endpackage

FILE: hdl/wav_header_chunk_parser_unit.sv
// wav_header_chunk_parser_unit: byte-serial riff/wav header walker with a serial divider
// depends on wavhdr_pkg (request/result types, tags, status codes)
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  byte      | in        | byte_valid / byte_ready   | byte_data (byte_req_t)
//  result    | out       | result_valid/result_ready | result_data (result_t)
//
// one file byte is taken per cycle while the walker runs
// the request marked end_of_file is followed by the status decision; when the sample count is
// divided out, the 31-bit length goes through a restoring divider one quotient bit a cycle
// byte_ready stays low from the last byte until the result sits in the output register
// a result waiting on result_ready stalls only the final load, not the byte walk
// reset (rst_n low, asynchronous) clears the walker; it also restarts after every result
module wav_header_chunk_parser_unit
    import wavhdr_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  byte_req_t byte_data,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result_data
);

    // sequencer codes
    localparam logic [1:0] S_RUN = 2'd0;  // walking bytes
    localparam logic [1:0] S_FIN = 2'd1;  // status decision, divider load, walker clear
    localparam logic [1:0] S_DIV = 2'd2;  // one quotient bit per cycle
    localparam logic [1:0] S_OUT = 2'd3;  // load output register when it is free

    localparam logic [4:0] DIV_LAST = 5'(COUNT_W - 1);

    logic [1:0] state_reg, state_next;

    // walker state
    logic [OFFSET_BITS:0] pos_reg, pos_next;
    logic [NCS_W-1:0]     nxt_reg, nxt_next;
    logic [1:0]           phase_reg, phase_next;
    logic [31:0]          id_reg, id_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [4:0]           cap_reg, cap_next;
    logic [63:0]          fields_reg, fields_next;
    logic [15:0]          bits_reg, bits_next;
    logic [COUNT_W-1:0]   dlen_reg, dlen_next;
    logic [31:0]          doff_reg, doff_next;
    logic [2:0]           flags_reg, flags_next;

    // divider and pending result
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic [WIDTH_W-1:0] rem_reg, rem_next;
    logic [WIDTH_W-1:0] dvsr_reg, dvsr_next;
    logic [4:0]         cnt_reg, cnt_next;
    result_t            pend_reg, pend_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // walker helpers
    logic                 take;
    logic [7:0]           b;
    logic [NCS_W-1:0]     pos_ext;
    logic [NCS_W-1:0]     diff;
    logic                 at_start;
    logic                 k_small;
    logic [3:0]           k;
    logic [LEN_W-1:0]     hdr_len;
    logic [31:0]          id_shift;
    logic [NCS_W-1:0]     pad_len;
    logic [NCS_W-1:0]     body_start;

    // divider helpers
    logic [WIDTH_W:0] rem_shift;
    logic [WIDTH_W:0] rem_diff;
    logic             q_bit;

    // result decision helpers
    logic [15:0]        fin_fmt;
    logic [WIDTH_W-1:0] fin_width;

    assign byte_ready   = (state_reg == S_RUN);
    assign take         = byte_valid && byte_ready;
    assign b            = byte_data.file_byte;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // distance of the current byte from the next chunk header
    assign pos_ext    = {{(NCS_W - OFFSET_BITS){1'b0}}, pos_reg[OFFSET_BITS-1:0]};
    assign diff       = pos_ext - nxt_reg;
    assign at_start   = (pos_ext >= nxt_reg);
    assign k_small    = (diff[NCS_W-1:4] == '0);
    assign k          = diff[3:0];
    assign hdr_len    = {b, len_reg[LEN_W-1:8]};
    assign id_shift   = {id_reg[23:0], b};
    // body padded to even length
    assign pad_len    = ({{(NCS_W - LEN_W + 1){1'b0}}, hdr_len[LEN_W-2:0]} + NCS_W'(1))
                        & ~NCS_W'(1);
    assign body_start = nxt_reg + HDR_BYTES;

    assign fin_fmt   = fields_reg[15:0];
    assign fin_width = bits_reg[15:3];

    // restoring divide step
    assign rem_shift = {rem_reg, quo_reg[COUNT_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};
    assign q_bit     = (rem_shift >= {1'b0, dvsr_reg});

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        nxt_next       = nxt_reg;
        phase_next     = phase_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        cap_next       = cap_reg;
        fields_next    = fields_reg;
        bits_next      = bits_reg;
        dlen_next      = dlen_reg;
        doff_next      = doff_reg;
        flags_next     = flags_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvsr_next      = dvsr_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_RUN:
            begin
                if (take)
                begin
                    // bytes past the offset range are not parsed
                    if (!pos_reg[OFFSET_BITS])
                    begin
                        // fmt field capture runs ahead of the header walk
                        if (!cap_reg[4])
                        begin
                            if (!cap_reg[3])
                            begin
                                fields_next[{cap_reg[2:0], 3'b000} +: 8] = b;
                            end
                            else if (cap_reg[3:0] == 4'd14)
                            begin
                                bits_next[7:0] = b;
                            end
                            else if (cap_reg[3:0] == 4'd15)
                            begin
                                bits_next[15:8] = b;
                            end
                            cap_next = cap_reg + 5'd1;
                        end

                        if (at_start)
                        begin
                            unique case (phase_reg)
                                PH_SEEK, PH_SUB:
                                begin
                                    if (k_small && k < 4'd4)
                                    begin
                                        id_next = id_shift;
                                    end
                                    else if (k_small && k < 4'd8)
                                    begin
                                        len_next = hdr_len;
                                    end
                                    if (k_small && k == 4'd7)
                                    begin
                                        if (hdr_len[LEN_W-1])
                                        begin
                                            // negative length ends the walk
                                            phase_next = PH_STOP;
                                        end
                                        else if (phase_reg == PH_SEEK && id_reg == TAG_RIFF)
                                        begin
                                            phase_next = PH_WAVE;
                                        end
                                        else
                                        begin
                                            if (phase_reg == PH_SUB)
                                            begin
                                                if (id_reg == TAG_FMT && !flags_reg[FL_FMT])
                                                begin
                                                    flags_next[FL_FMT] = 1'b1;
                                                    cap_next           = 5'd0;
                                                end
                                                if (id_reg == TAG_DATA && !flags_reg[FL_DATA])
                                                begin
                                                    flags_next[FL_DATA] = 1'b1;
                                                    dlen_next = hdr_len[COUNT_W-1:0];
                                                    doff_next = body_start[31:0];
                                                end
                                            end
                                            nxt_next = body_start + pad_len;
                                        end
                                    end
                                end
                                PH_WAVE:
                                begin
                                    if (k_small && k >= 4'd8 && k < 4'd12)
                                    begin
                                        id_next = id_shift;
                                    end
                                    if (k_small && k == 4'd11)
                                    begin
                                        if (id_shift == TAG_WAVE)
                                        begin
                                            flags_next[FL_WAVE] = 1'b1;
                                            phase_next          = PH_SUB;
                                            nxt_next            = nxt_reg + RIFF_HDR;
                                        end
                                        else
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                    end
                                end
                                PH_STOP:
                                begin
                                end
                            endcase
                        end
                        pos_next = pos_reg + 1'b1;
                    end

                    if (byte_data.end_of_file)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_FIN:
            begin
                pend_next = '0;
                quo_next  = '0;
                rem_next  = '0;
                dvsr_next = fin_width;
                cnt_next  = DIV_LAST;
                state_next = S_OUT;
                priority if (!flags_reg[FL_WAVE])
                begin
                    pend_next.parse_status = ST_NO_RIFF;
                end
                else if (!flags_reg[FL_FMT])
                begin
                    pend_next.parse_status = ST_NO_FMT;
                end
                else
                begin
                    pend_next.audio_format     = fin_fmt;
                    pend_next.channel_count    = fields_reg[31:16];
                    pend_next.sample_rate      = fields_reg[63:32];
                    pend_next.bytes_per_sample = fin_width;
                    priority if (fin_fmt != FMT_PCM)
                    begin
                        pend_next.parse_status = ST_NOT_PCM;
                    end
                    else if (!flags_reg[FL_DATA])
                    begin
                        pend_next.parse_status = ST_NO_DATA;
                    end
                    else
                    begin
                        pend_next.data_offset = doff_reg;
                        if (fin_width == '0)
                        begin
                            pend_next.parse_status = ST_ZERO_WIDTH;
                        end
                        else
                        begin
                            pend_next.parse_status = ST_OK;
                            quo_next   = dlen_reg;
                            state_next = S_DIV;
                        end
                    end
                end

                // walker back to its start for the next file
                pos_next    = '0;
                nxt_next    = '0;
                phase_next  = PH_SEEK;
                id_next     = '0;
                len_next    = '0;
                cap_next    = CAP_IDLE;
                fields_next = '0;
                bits_next   = '0;
                dlen_next   = '0;
                doff_next   = '0;
                flags_next  = '0;
            end

            S_DIV:
            begin
                if (q_bit)
                begin
                    rem_next = rem_diff[WIDTH_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[WIDTH_W-1:0];
                end
                quo_next = {quo_reg[COUNT_W-2:0], q_bit};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next              = pend_reg;
                    out_next.sample_count = quo_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            nxt_reg       <= '0;
            phase_reg     <= PH_SEEK;
            id_reg        <= '0;
            len_reg       <= '0;
            cap_reg       <= CAP_IDLE;
            fields_reg    <= '0;
            bits_reg      <= '0;
            dlen_reg      <= '0;
            doff_reg      <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            nxt_reg       <= nxt_next;
            phase_reg     <= phase_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            cap_reg       <= cap_next;
            fields_reg    <= fields_next;
            bits_reg      <= bits_next;
            dlen_reg      <= dlen_next;
            doff_reg      <= doff_next;
            flags_reg     <= flags_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // last byte stops intake until the result is loaded
    a_eof_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (take && byte_data.end_of_file) |=> !byte_ready)
        else $error("byte intake not stopped after last byte");

    // only a clean parse carries a sample count
    a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.parse_status != ST_OK) |-> result_data.sample_count == '0)
        else $error("sample count on a failed parse");

    // missing riff/wave or fmt reports no fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.parse_status == ST_NO_RIFF ||
                          result_data.parse_status == ST_NO_FMT))
        |-> (result_data.audio_format == '0 && result_data.data_offset == '0))
        else $error("fields reported without fmt");

    // capture offset never runs past idle
    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= CAP_IDLE)
        else $error("fmt capture offset out of range");

endmodule
